// File: design/bwdif_pkg.sv
// Shared types and constants of the BWDIF pixel interpolator.
// No dependencies; the channel interfaces and all modules import this package.
`default_nettype none

package bwdif_pkg;

	localparam int FRAC_BITS = 13;
	localparam int SP_NEAR   = 5077;
	localparam int SP_FAR    = 981;
	localparam int HF_0      = 5570;
	localparam int HF_2      = 3801;
	localparam int HF_4      = 1016;
	localparam int LF_NEAR   = 4309;
	localparam int LF_FAR    = 213;

	localparam int PREV_W = 56;
	localparam int ROWS_W = 32;
	localparam int PIX_W  = 8;
	localparam int MODE_W = 2;

	typedef enum logic [MODE_W-1:0] {
		MODE_EDGE     = 2'd0,
		MODE_INTRA    = 2'd1,
		MODE_TEMPORAL = 2'd2
	} mode_t;

	typedef logic [PIX_W-1:0] pix_t;

	// Taps that the motion limit is formed from.
	typedef struct packed {
		pix_t p0;
		pix_t c0;
		pix_t pab;
		pix_t pbe;
		pix_t up;
		pix_t lo;
		pix_t nab;
		pix_t nbe;
		pix_t pm2;
		pix_t cm2;
		pix_t pp2;
		pix_t cp2;
	} taps_t;

	// Temporal centre, base limit, predictor select and the terms of the spatial widening.
	typedef struct packed {
		pix_t              centre;
		pix_t              base;
		logic              hf_sel;
		logic signed [9:0] udiff;
		logic signed [9:0] ldiff;
		logic signed [9:0] uc;
		logic signed [9:0] lc;
	} lim_t;

endpackage

`default_nettype wire

// File: design/bwdif_taps_if.sv
// Input channel of the interpolator: one column of taps per request.
// Depends on bwdif_pkg for the field widths.
`default_nettype none

interface bwdif_taps_if
	import bwdif_pkg::*;
;
	logic                valid;
	logic                ready;
	logic [PREV_W-1:0]   prev_column;
	logic [ROWS_W-1:0]   cur_upper;
	logic [PIX_W-1:0]    cur_center;
	logic [ROWS_W-1:0]   cur_lower;
	logic [PIX_W-1:0]    next_above;
	logic [PIX_W-1:0]    next_below;
	logic [MODE_W-1:0]   filter_mode;
	logic                spatial_check;

	modport source (
		output valid, prev_column, cur_upper, cur_center, cur_lower,
		output next_above, next_below, filter_mode, spatial_check,
		input  ready
	);

	modport sink (
		input  valid, prev_column, cur_upper, cur_center, cur_lower,
		input  next_above, next_below, filter_mode, spatial_check,
		output ready
	);
endinterface

`default_nettype wire

// File: design/bwdif_pixel_if.sv
// Output channel of the interpolator: one pixel per request.
// Depends on bwdif_pkg for the pixel width.
`default_nettype none

interface bwdif_pixel_if
	import bwdif_pkg::*;
;
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel_out;

	modport source (output valid, pixel_out, input ready);
	modport sink   (input valid, pixel_out, output ready);
endinterface

`default_nettype wire

// File: design/bwdif_motion.sv
// Temporal centre, motion and base motion limit, plus the spatial widening terms.
// Combinational; depends on bwdif_pkg.
`default_nettype none

module bwdif_motion
	import bwdif_pkg::*;
(
	input  var taps_t taps,
	output var lim_t  lim
);

	function automatic pix_t absdiff(input pix_t a, input pix_t b);
		logic [8:0] d;
		d = {1'b0, a} - {1'b0, b};
		return d[8] ? 8'(-d) : d[7:0];
	endfunction

	logic [8:0] sum_c, sum_prev, sum_next, sum_u2, sum_l2;
	pix_t       motion, half_m, half_p, half_n, centre, vdiff;

	always_comb begin
		sum_c    = {1'b0, taps.p0} + {1'b0, taps.c0};
		centre   = sum_c[8:1];
		motion   = absdiff(taps.p0, taps.c0);
		sum_prev = {1'b0, absdiff(taps.pab, taps.up)} + {1'b0, absdiff(taps.pbe, taps.lo)};
		sum_next = {1'b0, absdiff(taps.nab, taps.up)} + {1'b0, absdiff(taps.nbe, taps.lo)};
		half_m   = {1'b0, motion[7:1]};
		half_p   = sum_prev[8:1];
		half_n   = sum_next[8:1];
		vdiff    = absdiff(taps.up, taps.lo);
		sum_u2   = {1'b0, taps.pm2} + {1'b0, taps.cm2};
		sum_l2   = {1'b0, taps.pp2} + {1'b0, taps.cp2};

		lim.centre = centre;
		lim.base   = half_m;
		if (half_p > lim.base) begin
			lim.base = half_p;
		end
		if (half_n > lim.base) begin
			lim.base = half_n;
		end
		lim.hf_sel = vdiff > motion;
		lim.udiff  = $signed({2'b00, sum_u2[8:1]}) - $signed({2'b00, taps.up});
		lim.ldiff  = $signed({2'b00, sum_l2[8:1]}) - $signed({2'b00, taps.lo});
		lim.uc     = $signed({2'b00, centre}) - $signed({2'b00, taps.up});
		lim.lc     = $signed({2'b00, centre}) - $signed({2'b00, taps.lo});
	end

endmodule

`default_nettype wire

// File: design/bwdif_pixel_interpolator_unit.sv
// BWDIF missing-line pixel interpolator: a four-stage pipeline that accepts one tap
// column and delivers one pixel per clock while the output is not stalled.
// Depends on bwdif_pkg, bwdif_taps_if, bwdif_pixel_if and bwdif_motion.
//
// Each request carries a vertical column of previous, current and next field bytes and
// yields one interpolated pixel. Stage 1 unpacks the taps and forms the motion limit,
// stage 2 applies the constant filter multiplies and the spatial widening of the limit,
// stage 3 sums and scales the predictors, and stage 4 clamps to the motion envelope and
// to 0..255 into the output register. A new request is taken every clock as long as the
// consumer keeps up; on an output stall a full stage holds only if the next one holds.
`default_nettype none

module bwdif_pixel_interpolator_unit
	import bwdif_pkg::*;
(
	input  wire            clk,
	input  wire            arst_n,
	bwdif_taps_if.sink     taps,
	bwdif_pixel_if.source  result
);

	logic adv1, adv2, adv3, adv4;
	logic v_s1, v_s2, v_s3, v_s4;

	assign adv4 = !v_s4 || result.ready;
	assign adv3 = !v_s3 || adv4;
	assign adv2 = !v_s2 || adv3;
	assign adv1 = !v_s1 || adv2;
	assign taps.ready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (adv1) begin
				v_s1 <= taps.valid;
			end
			if (adv2) begin
				v_s2 <= v_s1;
			end
			if (adv3) begin
				v_s3 <= v_s2;
			end
			if (adv4) begin
				v_s4 <= v_s3;
			end
		end
	end

	// Stage 1: unpack, tap sums and motion limit.
	taps_t tp;
	lim_t  lim;
	pix_t  pm4, pp4, cm4, cm3, cp3, cp4;

	always_comb begin
		pm4    = taps.prev_column[7:0];
		tp.pm2 = taps.prev_column[15:8];
		tp.pab = taps.prev_column[23:16];
		tp.p0  = taps.prev_column[31:24];
		tp.pbe = taps.prev_column[39:32];
		tp.pp2 = taps.prev_column[47:40];
		pp4    = taps.prev_column[55:48];
		cm4    = taps.cur_upper[7:0];
		cm3    = taps.cur_upper[15:8];
		tp.cm2 = taps.cur_upper[23:16];
		tp.up  = taps.cur_upper[31:24];
		tp.c0  = taps.cur_center;
		tp.lo  = taps.cur_lower[7:0];
		tp.cp2 = taps.cur_lower[15:8];
		cp3    = taps.cur_lower[23:16];
		cp4    = taps.cur_lower[31:24];
		tp.nab = taps.next_above;
		tp.nbe = taps.next_below;
	end

	bwdif_motion u_motion (
		.taps (tp),
		.lim  (lim)
	);

	mode_t      mode_s1;
	logic       spat_s1;
	logic [8:0] near_s1, far_s1, h0_s1;
	logic [9:0] h2_s1, h4_s1;
	lim_t       lim_s1;

	always_ff @(posedge clk) begin
		if (adv1) begin
			mode_s1 <= mode_t'(taps.filter_mode);
			spat_s1 <= taps.spatial_check;
			near_s1 <= {1'b0, tp.up} + {1'b0, tp.lo};
			far_s1  <= {1'b0, cm3} + {1'b0, cp3};
			h0_s1   <= {1'b0, tp.p0} + {1'b0, tp.c0};
			h2_s1   <= ({2'b00, tp.pm2} + {2'b00, tp.cm2})
			         + ({2'b00, tp.pp2} + {2'b00, tp.cp2});
			h4_s1   <= ({2'b00, pm4} + {2'b00, cm4}) + ({2'b00, pp4} + {2'b00, cp4});
			lim_s1  <= lim;
		end
	end

	// Stage 2: constant multiplies and spatial widening of the limit.
	logic signed [9:0] mn, mx, wide;
	pix_t              limit_w;

	always_comb begin
		mn = (lim_s1.uc < lim_s1.lc) ? lim_s1.uc : lim_s1.lc;
		if (lim_s1.udiff > lim_s1.ldiff) begin
			if (lim_s1.udiff < mn) begin
				mn = lim_s1.udiff;
			end
		end else begin
			if (lim_s1.ldiff < mn) begin
				mn = lim_s1.ldiff;
			end
		end
		mx = (lim_s1.uc > lim_s1.lc) ? lim_s1.uc : lim_s1.lc;
		if (lim_s1.udiff < lim_s1.ldiff) begin
			if (lim_s1.udiff > mx) begin
				mx = lim_s1.udiff;
			end
		end else begin
			if (lim_s1.ldiff > mx) begin
				mx = lim_s1.ldiff;
			end
		end
		wide = (mn > -mx) ? mn : -mx;
		limit_w = lim_s1.base;
		if (spat_s1 && (wide > $signed({2'b00, lim_s1.base}))) begin
			limit_w = wide[7:0];
		end
	end

	mode_t       mode_s2;
	logic        hfsel_s2, zero_s2;
	pix_t        centre_s2, limit_s2, edge_s2;
	logic [21:0] spn_s2, hf0_s2, hf2_s2, lfn_s2;
	logic [18:0] spf_s2;
	logic [19:0] hf4_s2;
	logic [16:0] lff_s2;

	always_ff @(posedge clk) begin
		if (adv2) begin
			mode_s2   <= mode_s1;
			hfsel_s2  <= lim_s1.hf_sel;
			zero_s2   <= (lim_s1.base == '0);
			centre_s2 <= lim_s1.centre;
			limit_s2  <= limit_w;
			edge_s2   <= near_s1[8:1];
			spn_s2    <= 22'(near_s1) * 22'(SP_NEAR);
			spf_s2    <= 19'(far_s1) * 19'(SP_FAR);
			hf0_s2    <= 22'(h0_s1) * 22'(HF_0);
			hf2_s2    <= 22'(h2_s1) * 22'(HF_2);
			hf4_s2    <= 20'(h4_s1) * 20'(HF_4);
			lfn_s2    <= 22'(near_s1) * 22'(LF_NEAR);
			lff_s2    <= 17'(far_s1) * 17'(LF_FAR);
		end
	end

	// Stage 3: predictor sums, scaling and the clamp bounds.
	logic signed [23:0] sp_sum, hf_sum, lf_sum;
	logic signed [10:0] sp_pred, tp_pred, pred;

	always_comb begin
		sp_sum  = $signed({2'b00, spn_s2}) - $signed({5'b00000, spf_s2});
		hf_sum  = $signed({2'b00, hf0_s2}) - $signed({2'b00, hf2_s2})
		        + $signed({4'b0000, hf4_s2});
		lf_sum  = (hf_sum >>> 2) + $signed({2'b00, lfn_s2}) - $signed({7'b0000000, lff_s2});
		sp_pred = 11'(sp_sum >>> FRAC_BITS);
		tp_pred = 11'(lf_sum >>> FRAC_BITS);
		case (mode_s2)
			MODE_INTRA:    pred = sp_pred;
			MODE_TEMPORAL: pred = hfsel_s2 ? tp_pred : sp_pred;
			default:       pred = $signed({3'b000, edge_s2});
		endcase
	end

	logic               intra_s3, zero_s3;
	pix_t               centre_s3;
	logic signed [10:0] pred_s3, lo_s3, hi_s3;

	always_ff @(posedge clk) begin
		if (adv3) begin
			intra_s3  <= (mode_s2 == MODE_INTRA);
			zero_s3   <= zero_s2;
			centre_s3 <= centre_s2;
			pred_s3   <= pred;
			lo_s3     <= $signed({3'b000, centre_s2}) - $signed({3'b000, limit_s2});
			hi_s3     <= $signed({3'b000, centre_s2}) + $signed({3'b000, limit_s2});
		end
	end

	// Stage 4: envelope and range clamp into the output register.
	logic signed [10:0] env;
	pix_t               pix;

	always_comb begin
		env = pred_s3;
		if (!intra_s3) begin
			if (pred_s3 < lo_s3) begin
				env = lo_s3;
			end else if (pred_s3 > hi_s3) begin
				env = hi_s3;
			end
		end
		if (env < 0) begin
			pix = '0;
		end else if (env > 11'sd255) begin
			pix = 8'hff;
		end else begin
			pix = env[7:0];
		end
		if (!intra_s3 && zero_s3) begin
			pix = centre_s3;
		end
	end

	pix_t pixel_s4;

	always_ff @(posedge clk) begin
		if (adv4) begin
			pixel_s4 <= pix;
		end
	end

	assign result.valid     = v_s4;
	assign result.pixel_out = pixel_s4;

endmodule

`default_nettype wire

// File: dv/tb_bwdif_pixel_interpolator_unit.sv
// Self-checking testbench of the BWDIF pixel interpolator: directed and random tap columns
// go through the request handshake and every pixel is checked against an in-bench predictor.
// Depends on bwdif_pkg, bwdif_taps_if, bwdif_pixel_if and bwdif_pixel_interpolator_unit.
`default_nettype none

module tb_bwdif_pixel_interpolator_unit;
	import bwdif_pkg::*;

	localparam int CLK_HALF    = 4;
	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_N    = 1750;
	localparam int IDLE_PCT    = 23;
	localparam int TAIL_CYCLES = 12;

	localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

	typedef struct {
		logic [PREV_W-1:0] prev_column;
		logic [ROWS_W-1:0] cur_upper;
		pix_t              cur_center;
		logic [ROWS_W-1:0] cur_lower;
		pix_t              next_above;
		pix_t              next_below;
		logic [MODE_W-1:0] filter_mode;
		logic              spatial_check;
	} taps_req_t;

	typedef enum int {
		COL_NOISE,
		COL_SMOOTH,
		COL_STILL
	} column_kind_t;

	class pixel_scoreboard;
		pix_t expected_pixels[$];
		int   mismatches;
		int   checked;
		int   noted;

		function new();
			mismatches = 0;
			checked    = 0;
			noted      = 0;
		endfunction

		function int iabs(int v);
			return (v < 0) ? -v : v;
		endfunction

		function int imax(int a, int b);
			return (a > b) ? a : b;
		endfunction

		function int imin(int a, int b);
			return (a < b) ? a : b;
		endfunction

		function int iclamp(int v, int lo_v, int hi_v);
			if (v < lo_v) begin
				return lo_v;
			end
			if (v > hi_v) begin
				return hi_v;
			end
			return v;
		endfunction

		function pix_t interpolate_pixel(taps_req_t r);
			int p[7];
			int cu[4];
			int cl[4];
			int k;
			int c0, nab, nbe, farsum, centre, motion, limit, pred, t;
			int udiff, ldiff, uc, lc, mn, mx;
			for (k = 0; k < 7; k++) begin
				p[k] = int'(r.prev_column[8*k +: 8]);
			end
			for (k = 0; k < 4; k++) begin
				cu[k] = int'(r.cur_upper[8*k +: 8]);
				cl[k] = int'(r.cur_lower[8*k +: 8]);
			end
			c0     = int'(r.cur_center);
			nab    = int'(r.next_above);
			nbe    = int'(r.next_below);
			farsum = cu[1] + cl[2];
			if (r.filter_mode == MODE_INTRA) begin
				pred = (SP_NEAR * (cu[3] + cl[0]) - SP_FAR * farsum) >>> FRAC_BITS;
				return pix_t'(iclamp(pred, 0, 255));
			end
			centre = (p[3] + c0) >> 1;
			motion = iabs(p[3] - c0);
			limit  = imax(motion >> 1,
				imax((iabs(p[2] - cu[3]) + iabs(p[4] - cl[0])) >> 1,
					(iabs(nab - cu[3]) + iabs(nbe - cl[0])) >> 1));
			if (limit == 0) begin
				return pix_t'(centre);
			end
			if (r.spatial_check) begin
				udiff = ((p[1] + cu[2]) >> 1) - cu[3];
				ldiff = ((p[5] + cl[1]) >> 1) - cl[0];
				uc    = centre - cu[3];
				lc    = centre - cl[0];
				mn    = imin(imin(uc, lc), imax(udiff, ldiff));
				mx    = imax(imax(uc, lc), imin(udiff, ldiff));
				limit = imax(limit, imax(mn, -mx));
			end
			pred = (cu[3] + cl[0]) >> 1;
			if (r.filter_mode == MODE_TEMPORAL) begin
				if (iabs(cu[3] - cl[0]) > motion) begin
					t = HF_0 * (p[3] + c0)
						- HF_2 * (p[1] + cu[2] + p[5] + cl[1])
						+ HF_4 * (p[0] + cu[0] + p[6] + cl[3]);
					pred = ((t >>> 2) + LF_NEAR * (cu[3] + cl[0]) - LF_FAR * farsum)
						>>> FRAC_BITS;
				end else begin
					pred = (SP_NEAR * (cu[3] + cl[0]) - SP_FAR * farsum) >>> FRAC_BITS;
				end
			end
			return pix_t'(iclamp(iclamp(pred, centre - limit, centre + limit), 0, 255));
		endfunction

		function void note_request(taps_req_t r);
			expected_pixels.push_back(interpolate_pixel(r));
			noted++;
		endfunction

		function void check_pixel(pix_t actual);
			pix_t want;
			if (expected_pixels.size() == 0) begin
				$error("pixel_out unexpected: expected none, actual %0d", actual);
				mismatches++;
				return;
			end
			want = expected_pixels.pop_front();
			checked++;
			if (actual !== want) begin
				$error("pixel_out mismatch: expected %0d, actual %0d", want, actual);
				mismatches++;
			end
		endfunction

		function int pending();
			return expected_pixels.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	bit   steady;
	int   cycle_count;

	pixel_scoreboard sb;

	bwdif_taps_if  taps_ch();
	bwdif_pixel_if pixel_ch();

	bwdif_pixel_interpolator_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.taps   (taps_ch),
		.result (pixel_ch)
	);

	always #CLK_HALF clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_bwdif_pixel_interpolator_unit NOT OK");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (pixel_ch.valid === 1'b1 && pixel_ch.ready === 1'b1) begin
				sb.check_pixel(pixel_ch.pixel_out);
			end
			pixel_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
		end else begin
			pixel_ch.ready <= 1'b0;
		end
	end

	function automatic int jitter(int b, int d);
		int v;
		v = b + int'($urandom_range(2 * d)) - d;
		return (v < 0) ? 0 : ((v > 255) ? 255 : v);
	endfunction

	function automatic taps_req_t make_column(logic [PREV_W-1:0] prev, logic [ROWS_W-1:0] cu,
			pix_t c0, logic [ROWS_W-1:0] cl, pix_t na, pix_t nb, logic [MODE_W-1:0] mode,
			logic sp);
		taps_req_t r;
		r.prev_column   = prev;
		r.cur_upper     = cu;
		r.cur_center    = c0;
		r.cur_lower     = cl;
		r.next_above    = na;
		r.next_below    = nb;
		r.filter_mode   = mode;
		r.spatial_check = sp;
		return r;
	endfunction

	function automatic taps_req_t random_column(column_kind_t kind);
		taps_req_t r;
		int b;
		int d;
		int k;
		b = $urandom_range(255);
		d = $urandom_range(48, 1);
		r.prev_column   = PREV_W'({$urandom(), $urandom()});
		r.cur_upper     = $urandom();
		r.cur_center    = pix_t'($urandom());
		r.cur_lower     = $urandom();
		r.next_above    = pix_t'($urandom());
		r.next_below    = pix_t'($urandom());
		r.filter_mode   = ($urandom_range(9) == 0) ? MODE_SPARE : MODE_W'($urandom_range(2));
		r.spatial_check = 1'($urandom());
		if (kind != COL_NOISE) begin
			for (k = 0; k < 7; k++) begin
				r.prev_column[8*k +: 8] = 8'(jitter(b, d));
			end
			for (k = 0; k < 4; k++) begin
				r.cur_upper[8*k +: 8] = 8'(jitter(b, d));
				r.cur_lower[8*k +: 8] = 8'(jitter(b, d));
			end
			r.cur_center = pix_t'(jitter(b, d));
			r.next_above = pix_t'(jitter(b, d));
			r.next_below = pix_t'(jitter(b, d));
		end
		if (kind == COL_STILL) begin
			r.cur_center           = r.prev_column[31:24];
			r.prev_column[23:16]   = r.cur_upper[31:24];
			r.prev_column[39:32]   = r.cur_lower[7:0];
			r.next_above           = r.cur_upper[31:24];
			r.next_below           = r.cur_lower[7:0];
		end
		return r;
	endfunction

	task automatic send_request(input taps_req_t r);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			taps_ch.valid <= 1'b0;
			@(posedge clk);
		end
		taps_ch.valid         <= 1'b1;
		taps_ch.prev_column   <= r.prev_column;
		taps_ch.cur_upper     <= r.cur_upper;
		taps_ch.cur_center    <= r.cur_center;
		taps_ch.cur_lower     <= r.cur_lower;
		taps_ch.next_above    <= r.next_above;
		taps_ch.next_below    <= r.next_below;
		taps_ch.filter_mode   <= r.filter_mode;
		taps_ch.spatial_check <= r.spatial_check;
		@(posedge clk);
		while (taps_ch.ready !== 1'b1) begin
			@(posedge clk);
		end
		sb.note_request(r);
	endtask

	task automatic hold_until_drained();
		taps_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) begin
			@(posedge clk);
		end
	endtask

	initial begin
		taps_req_t    r;
		column_kind_t kind;
		int           i;
		int           m;
		int           roll;
		sb          = new();
		steady      = 1'b0;
		arst_n      = 1'b0;
		taps_ch.valid         <= 1'b0;
		taps_ch.prev_column   <= '0;
		taps_ch.cur_upper     <= '0;
		taps_ch.cur_center    <= '0;
		taps_ch.cur_lower     <= '0;
		taps_ch.next_above    <= '0;
		taps_ch.next_below    <= '0;
		taps_ch.filter_mode   <= MODE_EDGE;
		taps_ch.spatial_check <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(make_column('0, '0, 8'h00, '0, 8'h00, 8'h00, MODE_EDGE, 1'b0));
		send_request(make_column('1, '1, 8'hFF, '1, 8'hFF, 8'hFF, MODE_EDGE, 1'b1));
		send_request(make_column('1, '1, 8'hFF, '1, 8'hFF, 8'hFF, MODE_INTRA, 1'b1));
		send_request(make_column('1, '1, 8'hFF, '1, 8'hFF, 8'hFF, MODE_TEMPORAL, 1'b1));
		send_request(make_column('1, '1, 8'hFF, '1, 8'hFF, 8'hFF, MODE_SPARE, 1'b0));
		send_request(make_column('0, 32'hFF000000, 8'h00, 32'h000000FF, 8'h00, 8'h00,
			MODE_INTRA, 1'b0));
		send_request(make_column('1, 32'h0000FF00, 8'hFF, 32'h00FF0000, 8'hFF, 8'hFF,
			MODE_INTRA, 1'b1));
		send_request(make_column(56'h0000C080400000, 32'h40000000, 8'h80, 32'h000000C0,
			8'h40, 8'hC0, MODE_TEMPORAL, 1'b1));
		send_request(make_column(56'h00000080000000, 32'h00000000, 8'h80, 32'h000000FF,
			8'h00, 8'h00, MODE_TEMPORAL, 1'b0));
		send_request(make_column(56'h00000080000000, 32'h00000000, 8'h80, 32'h000000FF,
			8'h00, 8'h00, MODE_TEMPORAL, 1'b1));
		send_request(make_column(56'h000000FF000000, 32'h64000000, 8'h00, 32'h00000064,
			8'h64, 8'h64, MODE_TEMPORAL, 1'b0));
		send_request(make_column(56'h000000FF000000, 32'h64000000, 8'h00, 32'h00000064,
			8'h64, 8'h64, MODE_EDGE, 1'b1));
		send_request(make_column(56'h000000FF000000, 32'h64000000, 8'h00, 32'h00000064,
			8'h64, 8'h64, MODE_SPARE, 1'b1));
		send_request(make_column(56'h00FF00000AFF00, 32'h00FF0000, 8'h00, 32'h0000FF00,
			8'h00, 8'h00, MODE_TEMPORAL, 1'b1));
		send_request(make_column(56'h00FF00000AFF00, 32'h00FF0000, 8'h00, 32'h0000FF00,
			8'h00, 8'h00, MODE_EDGE, 1'b1));
		send_request(make_column(56'h0000FFFFF50000, 32'hFF000000, 8'hFF, 32'h000000FF,
			8'hFF, 8'hFF, MODE_TEMPORAL, 1'b1));
		for (m = 0; m < 8; m++) begin
			r = random_column(COL_NOISE);
			r.filter_mode   = MODE_W'(m >> 1);
			r.spatial_check = m[0];
			send_request(r);
		end

		// The source stays quiet here until the pipeline has emptied.
		hold_until_drained();

		for (i = 0; i < RANDOM_N; i++) begin
			steady = (i >= 500 && i < 900);
			roll   = $urandom_range(99);
			kind   = (roll < 25) ? COL_NOISE : ((roll < 45) ? COL_STILL : COL_SMOOTH);
			send_request(random_column(kind));
			if (i == 1200) begin
				hold_until_drained();
			end
		end
		steady = 1'b0;

		hold_until_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.pending() != 0) begin
			$error("pixel_out missing: expected %0d more, actual 0", sb.pending());
			sb.mismatches++;
		end

		$display("Run covered %0d tap columns in edge, intra, temporal and the unused mode code,",
			sb.noted);
		$display("with still, smooth and noisy columns; %0d pixels were checked.", sb.checked);
		if (sb.mismatches == 0) begin
			$display("tb_bwdif_pixel_interpolator_unit OK");
		end else begin
			$display("tb_bwdif_pixel_interpolator_unit NOT OK");
		end
		$finish;
	end

endmodule

`default_nettype wire
